>>> rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants for the sorted list with insert, delete and dump.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CMP_W   = (FILL_W > POS_W) ? FILL_W : POS_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
        logic        [POS_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  entry;
        logic        [COUNT_W-1:0]  count;
        logic                       last;
    } t_out_item;

    // Broadcast from the control to every cell of the chain
    typedef struct packed {
        t_cell_cmd                  cmd;
        logic signed [VALUE_W-1:0]  value;
        logic        [POS_W-1:0]    position;
        logic        [FILL_W-1:0]   fill;
    } t_cell_op;

endpackage

>>> rtl/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain: compare, take the new value, shift from a neighbour, or hold.
// ----------------------------------------------------------------------------
module slid_cell (
    input  logic                                i_clk,
    input  logic [slid_pkg::IDX_W-1:0]          i_idx,
    input  slid_pkg::t_cell_op                  i_op,
    input  logic signed [slid_pkg::VALUE_W-1:0] i_left_val,
    input  logic                                i_left_gt,
    input  logic signed [slid_pkg::VALUE_W-1:0] i_right_val,
    input  logic signed [slid_pkg::VALUE_W-1:0] i_head_val,
    output logic signed [slid_pkg::VALUE_W-1:0] o_val,
    output logic                                o_gt
);
    import slid_pkg::*;

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;
    logic [FILL_W-1:0]         w_idx;
    logic                      w_occupied;

    assign w_idx      = FILL_W'(i_idx);
    assign w_occupied = (w_idx < i_op.fill);
    assign o_gt       = w_occupied && (r_val > i_op.value);
    assign o_val      = r_val;

    always_comb begin
        n_val = r_val;
        case (i_op.cmd)
            CELL_INSERT: begin
                // take the left slot's value when it moves up, else drop the new one in
                if (i_left_gt) begin
                    n_val = i_left_val;
                end else if (o_gt || (w_idx == i_op.fill)) begin
                    n_val = i_op.value;
                end
            end
            CELL_DELETE: begin
                if (CMP_W'(i_idx) >= CMP_W'(i_op.position)) begin
                    n_val = i_right_val;
                end
            end
            CELL_ROTATE: begin
                // wrap the head round to the last occupied slot
                if (w_idx == i_op.fill - FILL_W'(1)) begin
                    n_val = i_head_val;
                end else begin
                    n_val = i_right_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  input   | in        | i_in_valid / o_in_ready | i_in  (cmd, value, position)
//  output  | out       | o_out_valid/i_out_ready | o_out (status, entry, count, last)
//
//  Insert, delete and unknown commands: the result item is registered at the
//  accepting edge.
//  Dump: the accepting edge only starts the run; then one item per cycle,
//  count items in all, paced by the output handshake; the chain rotates
//  once per item and is back in order at the end.
//  Reset clears the fill count, the dump state and the output valid; slot
//  contents are undefined until written.
//  An input item is taken only while no dump runs and the output register is
//  empty or being emptied in the same cycle.
//
module sorted_list_insert_delete (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slid_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slid_pkg::t_out_item o_out
);
    import slid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state,     n_state;
    logic [FILL_W-1:0]  r_fill,      n_fill;
    logic [FILL_W-1:0]  r_remain,    n_remain;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out,       n_out;

    logic               w_out_free;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_pos_ok;
    logic               w_dump_step;
    t_cell_op           w_op;

    logic signed [VALUE_W-1:0] w_val [DEPTH];
    logic                      w_gt  [DEPTH];

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_fill == FILL_W'(DEPTH));
    assign w_empty     = (r_fill == '0);
    assign w_pos_ok    = (CMP_W'(i_in.position) < CMP_W'(r_fill));
    assign w_dump_step = (r_state == S_DUMP) && w_out_free;

    // Broadcast to the chain
    always_comb begin
        w_op.cmd      = CELL_HOLD;
        w_op.value    = i_in.value;
        w_op.position = i_in.position;
        w_op.fill     = r_fill;
        if (w_dump_step) begin
            w_op.cmd = CELL_ROTATE;
        end else if (w_accept) begin
            if ((i_in.cmd == CMD_INSERT) && !w_full) begin
                w_op.cmd = CELL_INSERT;
            end else if ((i_in.cmd == CMD_DELETE) && !w_empty && w_pos_ok) begin
                w_op.cmd = CELL_DELETE;
            end
        end
    end

    // Chain of cells; each looks at its neighbours, the head slot and the broadcast op
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left_val;
        logic                      w_left_gt;
        logic signed [VALUE_W-1:0] w_right_val;

        if (g == 0) begin : g_first
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_inner
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        slid_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (IDX_W'(g)),
            .i_op        (w_op),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    // Control and result register
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (w_dump_step) begin
            // stream the head; the chain rotates behind it
            n_out_valid  = 1'b1;
            n_out.status = ST_OK;
            n_out.entry  = w_val[0];
            n_out.count  = COUNT_W'(r_fill);
            n_out.last   = (r_remain == FILL_W'(1));
            n_remain     = r_remain - FILL_W'(1);
            if (r_remain == FILL_W'(1)) begin
                n_state = S_IDLE;
            end
        end else if (w_accept) begin
            n_out.status = ST_OK;
            n_out.entry  = '0;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
            case (i_in.cmd)
                CMD_INSERT: begin
                    if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                CMD_DELETE: begin
                    if (w_empty) begin
                        n_out.status = ST_EMPTY;
                    end else if (!w_pos_ok) begin
                        n_out.status = ST_RANGE;
                    end else begin
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                CMD_DUMP: begin
                    if (w_empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        // hold the output back; the dump loop fills it
                        n_out_valid = r_out_valid && !i_out_ready;
                        n_state     = S_DUMP;
                        n_remain    = r_fill;
                    end
                end
                default: begin
                    n_out.status = ST_OK;
                end
            endcase
            n_out.count = COUNT_W'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/slid_checker.sv
// ----------------------------------------------------------------------------
// slid_checker
// Port-level checks on the sorted list, attached to the top level by bind.
// ----------------------------------------------------------------------------
module slid_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  slid_pkg::t_in_item  i_in,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  slid_pkg::t_out_item o_out
);
    import slid_pkg::*;

    // hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result item changed while stalled");

    // only a dump item may lack the last mark
    a_run_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> ((o_out.status == ST_OK) && (o_out.count != '0)))
        else $error("unfinished run with bad status or empty count");

    // no new item while a dump run is still going
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> !o_in_ready)
        else $error("input taken in the middle of a dump run");

    // a full refusal reports a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == ST_FULL)) |-> (int'(o_out.count) == DEPTH))
        else $error("full status with count below depth");

    // count stays within the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out.count) <= DEPTH))
        else $error("count beyond depth");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted list: a directed table covering empty,
// range and full cases, then phased random traffic that grows and drains the
// list, with every result item compared against a typed-in result or an in-bench list predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import slid_pkg::*;

    // Idle cycles with no handshake on either channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching once nothing is outstanding
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 250;
    localparam int PHASE_ITEMS    = 30;

    // One directed row: the stimulus and, where it is obvious, the single result
    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item result;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    // Predicted contents of the list
    logic signed [VALUE_W-1:0] list_slots [DEPTH];
    int                        list_fill;

    t_out_item expected_results [$];
    t_dir_row  dir_rows [$];
    int        error_count = 0;
    int        idle_cycles = 0;

    sorted_list_insert_delete u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item make_result(t_status st, logic signed [VALUE_W-1:0] ent,
                                              int cnt, logic fin);
        t_out_item r;
        r.status = st;
        r.entry  = ent;
        r.count  = COUNT_W'(cnt);
        r.last   = fin;
        return r;
    endfunction

    // Apply one command to the predicted list and queue the result items it yields
    function automatic void predict_list_op(t_in_item it, ref t_out_item q[$]);
        int at;
        case (it.cmd)
            CMD_INSERT: begin
                if (list_fill >= DEPTH) begin
                    q.push_back(make_result(ST_FULL, '0, list_fill, 1'b1));
                end else begin
                    // Place before the first strictly greater entry: equals keep order
                    at = list_fill;
                    for (int k = 0; k < list_fill; k++) begin
                        if (list_slots[k] > it.value) begin
                            at = k;
                            break;
                        end
                    end
                    for (int k = list_fill; k > at; k--)
                        list_slots[k] = list_slots[k-1];
                    list_slots[at] = it.value;
                    list_fill++;
                    q.push_back(make_result(ST_OK, '0, list_fill, 1'b1));
                end
            end
            CMD_DELETE: begin
                // Empty takes precedence over an out-of-range position
                if (list_fill == 0) begin
                    q.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                end else if (int'(it.position) >= list_fill) begin
                    q.push_back(make_result(ST_RANGE, '0, list_fill, 1'b1));
                end else begin
                    for (int k = it.position; k + 1 < list_fill; k++)
                        list_slots[k] = list_slots[k+1];
                    list_fill--;
                    q.push_back(make_result(ST_OK, '0, list_fill, 1'b1));
                end
            end
            CMD_DUMP: begin
                if (list_fill == 0) begin
                    q.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                end else begin
                    for (int k = 0; k < list_fill; k++)
                        q.push_back(make_result(ST_OK, list_slots[k], list_fill,
                                                k + 1 == list_fill));
                end
            end
            default: begin
                // Unused code: list untouched, one plain result
                q.push_back(make_result(ST_OK, '0, list_fill, 1'b1));
            end
        endcase
    endfunction

    function automatic void add_row(t_cmd c, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p,
                                    bit typed, t_status st, int cnt);
        t_dir_row row;
        row.stim.cmd      = c;
        row.stim.value    = v;
        row.stim.position = p;
        row.typed         = typed;
        row.result        = make_result(st, '0, cnt, 1'b1);
        dir_rows.push_back(row);
    endfunction

    // Values: extremes, a narrow band to force duplicates, and full-range noise
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return VALUE_W'($signed($urandom_range(0, 16)) - 8);
            4:       return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
            default: return $urandom();
        endcase
    endfunction

    // Weighted command pick: phase 0 grows the list, phase 1 drains it, phase 2 mixes
    function automatic t_in_item make_random_item(int phase);
        t_in_item it;
        int       roll;
        int       ins_w;
        int       del_w;
        roll  = $urandom_range(0, 99);
        ins_w = (phase == 0) ? 70 : (phase == 1) ? 15 : 42;
        del_w = (phase == 0) ? 15 : (phase == 1) ? 70 : 38;
        if (roll < ins_w)
            it.cmd = CMD_INSERT;
        else if (roll < ins_w + del_w)
            it.cmd = CMD_DELETE;
        else if (roll < 95)
            it.cmd = CMD_DUMP;
        else
            it.cmd = CMD_NONE;
        it.value = pick_value();
        // Mostly valid positions; the rest span the whole field
        if (list_fill > 0 && $urandom_range(0, 9) < 8)
            it.position = POS_W'($urandom_range(0, list_fill - 1));
        else
            it.position = POS_W'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic int pick_gap(bit no_gaps);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Present one item and hold it until accepted; optionally hold off first
    // until every outstanding result item has been returned
    task automatic send_item(t_in_item item, int gap, bit drain);
        if (gap > 0 || drain) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Output side back-pressure: ready bursts, short stalls, occasional long ones
    initial begin
        int run_len;
        int stall_len;
        forever begin
            if ($urandom_range(0, 4) == 0) begin
                run_len = $urandom_range(30, 60);
            end else begin
                run_len = $urandom_range(1, 8);
            end
            stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            i_out_ready <= 1'b0;
            repeat (stall_len) @(posedge i_clk);
        end
    end

    // Compare each returned item, field by field, against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: status %0d entry %0d count %0d last %0d",
                       o_out.status, o_out.entry, o_out.count, o_out.last);
                error_count++;
            end else begin
                exp_item = expected_results.pop_front();
                if (o_out.status !== exp_item.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_item.status, o_out.status);
                    error_count++;
                end
                if (o_out.entry !== exp_item.entry) begin
                    $error("entry mismatch: expected %0d, actual %0d",
                           exp_item.entry, o_out.entry);
                    error_count++;
                end
                if (o_out.count !== exp_item.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           exp_item.count, o_out.count);
                    error_count++;
                end
                if (o_out.last !== exp_item.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           exp_item.last, o_out.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_out_item scratch [$];
        t_in_item  item;
        int        phase;
        bit        no_gaps;

        list_fill = 0;
        for (int k = 0; k < DEPTH; k++)
            list_slots[k] = '0;

        // Directed table: reset state and error cases first, then fill to the
        // brim, refuse one more, dump the full list and trim both ends
        add_row(CMD_DUMP,   '0,            5'd0,  1'b1, ST_EMPTY, 0);
        add_row(CMD_DELETE, '0,            5'd0,  1'b1, ST_EMPTY, 0);
        add_row(CMD_NONE,   32'shFFFF_FFFF, 5'd31, 1'b1, ST_OK,    0);
        add_row(CMD_INSERT, 32'sh7FFF_FFFF, 5'd0,  1'b1, ST_OK,    1);
        add_row(CMD_INSERT, 32'sh8000_0000, 5'd0,  1'b1, ST_OK,    2);
        add_row(CMD_INSERT, 32'sh0,         5'd0,  1'b0, ST_OK,    0);
        add_row(CMD_INSERT, 32'sh0,         5'd0,  1'b0, ST_OK,    0);
        add_row(CMD_DELETE, '0,            5'd4,  1'b1, ST_RANGE, 4);
        add_row(CMD_DELETE, '0,            5'd31, 1'b1, ST_RANGE, 4);
        add_row(CMD_DUMP,   '0,            5'd0,  1'b0, ST_OK,    0);
        for (int k = 0; k < DEPTH - 4; k++)
            add_row(CMD_INSERT, (k % 3 == 0) ? -32'sd3 : 32'(k * 1000 - 5000), 5'd0,
                    1'b0, ST_OK, 0);
        add_row(CMD_INSERT, 32'sd5,         5'd0,  1'b1, ST_FULL,  DEPTH);
        add_row(CMD_DUMP,   '0,            5'd0,  1'b0, ST_OK,    0);
        add_row(CMD_DELETE, '0,            5'(DEPTH - 1), 1'b0, ST_OK, 0);
        add_row(CMD_DELETE, '0,            5'd0,  1'b0, ST_OK,    0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].stim, pick_gap(1'b0), 1'b0);
            if (dir_rows[r].typed) begin
                // Advance the predicted list but trust the typed-in result
                scratch.delete();
                predict_list_op(dir_rows[r].stim, scratch);
                expected_results.push_back(dir_rows[r].result);
            end else begin
                predict_list_op(dir_rows[r].stim, expected_results);
            end
        end

        // Random part: phases that grow, drain or churn the list
        phase   = 0;
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                phase   = $urandom_range(0, 2);
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            item = make_random_item(phase);
            // Hold off until the pipe is empty mid-run, and now and then at random
            send_item(item, pick_gap(no_gaps),
                      n == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0);
            predict_list_op(item, expected_results);
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d result items never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
